// File: src/nnm_pkg.sv
// nnm_pkg: shared types and constants of the nonzero neighbour mean filter
// no dependencies; imported by every module of the block except nnm_ram
`default_nettype none
package nnm_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 16;                          // q8.8 pixel
  localparam int CW_W   = 7;                           // image_width register
  localparam int CH_W   = 11;                          // image_height register
  localparam int CFG_W  = 11;                          // widest register
  localparam int IDX_W  = 1;                           // register index
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);      // input row runs past the frame
  localparam int QROW_W = $clog2(MAX_HEIGHT);
  localparam int WIN_N  = 9;
  localparam int CNT_W  = 4;
  localparam int SUM_W  = PIX_W + 4;                   // signed sum of eight pixels
  localparam int MAG_W  = PIX_W + 3;                   // magnitude of that sum
  localparam int RCP_SH = MAG_W + 3;                   // reciprocal scale, exact for 1..8
  localparam int RCP_W  = RCP_SH + 1;
  localparam int LINE_W = 2 * PIX_W;                   // {older, newer} per column

  localparam logic [CW_W-1:0] WIDTH_RST  = CW_W'(64);
  localparam logic [CH_W-1:0] HEIGHT_RST = CH_W'(64);

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } nnm_reg_e;

  // per-item control, decided when the item is accepted
  typedef struct packed {
    logic emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } nnm_ctrl_t;

  // 3x3 window, row-major, raw pixel bits
  typedef logic [WIN_N-1:0][PIX_W-1:0] nnm_win_t;

endpackage
`default_nettype wire

// File: src/nnm_ram.sv
// nnm_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module nnm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/nnm_ctrl.sv
// nnm_ctrl: configuration registers, input and output position counters
// depends on nnm_pkg
`default_nettype none
module nnm_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [nnm_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [nnm_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                       take_i,
  input  wire logic                       op_i,
  input  wire logic [nnm_pkg::PIX_W-1:0]  pixel_i,
  output logic      [nnm_pkg::PIX_W-1:0]  pix_o,
  output logic      [nnm_pkg::COL_W-1:0]  col_o,
  output nnm_pkg::nnm_ctrl_t              ctrl_o
);
  import nnm_pkg::*;

  logic [CW_W-1:0]   cfg_w_q;
  logic [CH_W-1:0]   cfg_h_q;
  logic [COL_W-1:0]  col_q,  col_d;
  logic [ROW_W-1:0]  row_q,  row_d;
  logic [COL_W-1:0]  qc_q,   qc_d;
  logic [QROW_W-1:0] qr_q,   qr_d;
  logic [CW_W-1:0]   w_eff;
  logic [CH_W-1:0]   h_eff;
  logic [COL_W-1:0]  w_last;
  logic [QROW_W-1:0] h_last;
  logic              pix_in;
  nnm_ctrl_t         ctrl;

  // zero acts as one, oversize acts as the maximum
  assign w_eff = (cfg_w_q == '0) ? CW_W'(1) :
                 (cfg_w_q > CW_W'(MAX_WIDTH)) ? CW_W'(MAX_WIDTH) : cfg_w_q;
  assign h_eff = (cfg_h_q == '0) ? CH_W'(1) :
                 (cfg_h_q > CH_W'(MAX_HEIGHT)) ? CH_W'(MAX_HEIGHT) : cfg_h_q;
  assign w_last = COL_W'(w_eff - CW_W'(1));
  assign h_last = QROW_W'(h_eff - CH_W'(1));

  assign pix_in = row_q < ROW_W'(h_eff);
  assign pix_o  = (pix_in && !op_i) ? pixel_i : '0;
  assign col_o  = col_q;

  always_comb begin
    ctrl.emit     = (row_q > ROW_W'(1)) || ((row_q == ROW_W'(1)) && (col_q != '0));
    ctrl.top_ok   = qr_q != '0;
    ctrl.bot_ok   = qr_q != h_last;
    ctrl.left_ok  = qc_q != '0;
    ctrl.right_ok = qc_q != w_last;
    ctrl.last     = (qr_q == h_last) && (qc_q == w_last);
  end
  assign ctrl_o = ctrl;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    qc_d  = qc_q;
    qr_d  = qr_q;
    if (ctrl.emit && ctrl.last) begin
      col_d = '0;
      row_d = '0;
      qc_d  = '0;
      qr_d  = '0;
    end else begin
      if (col_q == w_last) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
      if (ctrl.emit) begin
        if (qc_q == w_last) begin
          qc_d = '0;
          qr_d = qr_q + QROW_W'(1);
        end else begin
          qc_d = qc_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= WIDTH_RST;
      cfg_h_q <= HEIGHT_RST;
      col_q   <= '0;
      row_q   <= '0;
      qc_q    <= '0;
      qr_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (nnm_reg_e'(cfg_index_i))
        REG_WIDTH:  cfg_w_q <= cfg_data_i[CW_W-1:0];
        REG_HEIGHT: cfg_h_q <= cfg_data_i[CH_W-1:0];
      endcase
      col_q <= '0;
      row_q <= '0;
      qc_q  <= '0;
      qr_q  <= '0;
    end else if (take_i) begin
      col_q <= col_d;
      row_q <= row_d;
      qc_q  <= qc_d;
      qr_q  <= qr_d;
    end
  end

endmodule
`default_nettype wire

// File: src/nnm_line.sv
// nnm_line: line store ram with read-modify-write, forwarding and 3x3 window
// depends on nnm_pkg and nnm_ram
`default_nettype none
module nnm_line (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      take_i,
  input  wire logic [nnm_pkg::PIX_W-1:0] pix_i,
  input  wire logic [nnm_pkg::COL_W-1:0] col_i,
  input  nnm_pkg::nnm_ctrl_t             ctrl_i,
  output nnm_pkg::nnm_win_t              win_o,
  output logic                           valid_o,
  output nnm_pkg::nnm_ctrl_t             ctrl_o
);
  import nnm_pkg::*;

  logic              s1_valid_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [COL_W-1:0]  s1_col_q;
  nnm_ctrl_t         s1_ctrl_q;
  logic              fwd_q;
  logic [PIX_W-1:0]  fwd_old_q;
  logic [PIX_W-1:0]  fwd_new_q;
  logic [LINE_W-1:0] rdata;
  logic [PIX_W-1:0]  cur_old;
  logic [PIX_W-1:0]  cur_new;
  nnm_win_t          win_q;
  logic              s2_valid_q;
  nnm_ctrl_t         s2_ctrl_q;

  nnm_ram #(
    .Width (LINE_W),
    .Depth (MAX_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (en_i && s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i ({cur_new, s1_pix_q}),
    .re_i    (en_i),
    .raddr_i (col_i),
    .rdata_o (rdata)
  );

  // same column written in the cycle it was read: take the values in flight
  assign cur_old = fwd_q ? fwd_old_q : rdata[LINE_W-1:PIX_W];
  assign cur_new = fwd_q ? fwd_new_q : rdata[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      s2_valid_q <= 1'b0;
      win_q      <= '0;
    end else if (en_i) begin
      s1_valid_q <= take_i;
      fwd_q      <= take_i && s1_valid_q && (col_i == s1_col_q);
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= cur_old;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= cur_new;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pix_q  <= pix_i;
      s1_col_q  <= col_i;
      s1_ctrl_q <= ctrl_i;
      fwd_old_q <= cur_new;
      fwd_new_q <= s1_pix_q;
      s2_ctrl_q <= s1_ctrl_q;
    end
  end

  assign win_o   = win_q;
  assign valid_o = s2_valid_q;
  assign ctrl_o  = s2_ctrl_q;

endmodule
`default_nettype wire

// File: src/nnm_mean.sv
// nnm_mean: masked neighbour sum, reciprocal multiply and output register
// depends on nnm_pkg
`default_nettype none
module nnm_mean (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  nnm_pkg::nnm_ctrl_t             ctrl_i,
  input  nnm_pkg::nnm_win_t              win_i,
  output logic                           valid_o,
  output logic signed [nnm_pkg::PIX_W-1:0] mean_o,
  output logic [nnm_pkg::CNT_W-1:0]      cnt_o,
  output logic                           last_o
);
  import nnm_pkg::*;

  localparam int RCP_ONE = 2 ** RCP_SH;

  // ceil(2^RCP_SH / d), exact truncating quotient for every sum magnitude
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RCP_W-1:0] r;
    case (d)
      CNT_W'(1): r = RCP_W'(RCP_ONE);
      CNT_W'(2): r = RCP_W'(RCP_ONE / 2);
      CNT_W'(3): r = RCP_W'((RCP_ONE + 2) / 3);
      CNT_W'(4): r = RCP_W'(RCP_ONE / 4);
      CNT_W'(5): r = RCP_W'((RCP_ONE + 4) / 5);
      CNT_W'(6): r = RCP_W'((RCP_ONE + 5) / 6);
      CNT_W'(7): r = RCP_W'((RCP_ONE + 6) / 7);
      CNT_W'(8): r = RCP_W'(RCP_ONE / 8);
      default:   r = '0;
    endcase
    return r;
  endfunction

  logic [WIN_N-1:0]          nb_en;
  logic signed [SUM_W-1:0]   sum_d;
  logic [CNT_W-1:0]          cnt_d;
  logic                      s3_valid_q;
  logic signed [SUM_W-1:0]   s3_sum_q;
  logic [CNT_W-1:0]          s3_cnt_q;
  logic                      s3_last_q;
  logic [MAG_W-1:0]          mag;
  logic                      s4_valid_q;
  logic [MAG_W+RCP_W-1:0]    s4_prod_q;
  logic                      s4_neg_q;
  logic [CNT_W-1:0]          s4_cnt_q;
  logic                      s4_last_q;
  logic [PIX_W-1:0]          quo;
  logic                      out_valid_q;
  logic [PIX_W-1:0]          out_mean_q;
  logic [CNT_W-1:0]          out_cnt_q;
  logic                      out_last_q;

  // out-of-frame neighbours and the centre are left out
  assign nb_en = {ctrl_i.bot_ok & ctrl_i.right_ok, ctrl_i.bot_ok, ctrl_i.bot_ok & ctrl_i.left_ok,
                  ctrl_i.right_ok, 1'b0, ctrl_i.left_ok,
                  ctrl_i.top_ok & ctrl_i.right_ok, ctrl_i.top_ok, ctrl_i.top_ok & ctrl_i.left_ok};

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int k = 0; k < WIN_N; k++) begin
      if (nb_en[k] && (win_i[k] != '0)) begin
        sum_d = sum_d + SUM_W'($signed(win_i[k]));
        cnt_d = cnt_d + CNT_W'(1);
      end
    end
  end

  assign mag = s3_sum_q[SUM_W-1] ? MAG_W'(-s3_sum_q) : MAG_W'(s3_sum_q);
  assign quo = s4_prod_q[RCP_SH +: PIX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q  <= valid_i && ctrl_i.emit;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sum_q   <= sum_d;
      s3_cnt_q   <= cnt_d;
      s3_last_q  <= ctrl_i.last;
      s4_prod_q  <= (MAG_W + RCP_W)'(mag) * (MAG_W + RCP_W)'(recip(s3_cnt_q));
      s4_neg_q   <= s3_sum_q[SUM_W-1];
      s4_cnt_q   <= s3_cnt_q;
      s4_last_q  <= s3_last_q;
      out_mean_q <= s4_neg_q ? PIX_W'(-quo) : quo;
      out_cnt_q  <= s4_cnt_q;
      out_last_q <= s4_last_q;
    end
  end

  assign valid_o = out_valid_q;
  assign mean_o  = $signed(out_mean_q);
  assign cnt_o   = out_cnt_q;
  assign last_o  = out_last_q;

endmodule
`default_nettype wire

// File: src/nonzero_neighbor_mean_3x3.sv
// nonzero_neighbor_mean_3x3: top level of the masked 3x3 neighbour mean filter
// pipeline: an item is registered in s1, the window, s3, s4 and the output register;
//   results lag the pixel stream by one row plus one pixel, width+1 flush items drain a frame
// throughput: one item per cycle but for stalls, set by the single read-modify-write of the ram
// reset: config returns to 64x64, counters and pipeline valids clear; the ram is not cleared
// depends on nnm_pkg, nnm_ctrl, nnm_line, nnm_mean, nnm_ram
`default_nettype none
module nonzero_neighbor_mean_3x3 (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [nnm_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [nnm_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       op_i,
  input  wire logic signed [nnm_pkg::PIX_W-1:0] pixel_value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [nnm_pkg::PIX_W-1:0] mean_value_o,
  output logic [nnm_pkg::CNT_W-1:0]       nonzero_count_o,
  output logic                            frame_last_o
);
  import nnm_pkg::*;

  logic             en;
  logic             take;
  logic [PIX_W-1:0] s0_pix;
  logic [COL_W-1:0] s0_col;
  nnm_ctrl_t        s0_ctrl;
  nnm_win_t         win;
  logic             s2_valid;
  nnm_ctrl_t        s2_ctrl;
  logic             out_valid;

  // whole pipeline moves together; it only holds while a result waits to be taken
  assign en         = !out_valid || !out_stall_i;
  assign in_stall_o = !en;
  assign take       = in_valid_i && en;

  // position counters and register file; picks the pixel or a zero fill
  nnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .op_i        (op_i),
    .pixel_i     (pixel_value_i),
    .pix_o       (s0_pix),
    .col_o       (s0_col),
    .ctrl_o      (s0_ctrl)
  );

  // line store read at transfer, written back from the s1 register, window shifted then
  nnm_line u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .take_i  (take),
    .pix_i   (s0_pix),
    .col_i   (s0_col),
    .ctrl_i  (s0_ctrl),
    .win_o   (win),
    .valid_o (s2_valid),
    .ctrl_o  (s2_ctrl)
  );

  // sum and count, reciprocal multiply, sign and output register
  nnm_mean u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid),
    .ctrl_i  (s2_ctrl),
    .win_i   (win),
    .valid_o (out_valid),
    .mean_o  (mean_value_o),
    .cnt_o   (nonzero_count_o),
    .last_o  (frame_last_o)
  );

  assign out_valid_o = out_valid;

  // input is only held back by a waiting result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  // at most eight neighbours
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nonzero_count_o <= CNT_W'(8)))
    else $error("neighbour count out of range");

  // no neighbour gives a zero mean
  a_zero_mean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (nonzero_count_o == '0)) |-> (mean_value_o == '0))
    else $error("nonzero mean with no neighbour");

  // a result is held while stalled, and then moves the pipeline on
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(mean_value_o)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
